// File: src/pds_pkg.sv
// ----------------------------------------------------------------------------
// PLL divider solver package
// Shared widths, limits, status codes and pipeline payload types.
// ----------------------------------------------------------------------------
package pds_pkg;

    localparam int FREQ_BITS         = 20;
    localparam int ACT_BITS          = 21;
    localparam int CW_BITS           = 14;
    localparam int MAIN_DIV_BITS_DEF = 9;

    // The quotient of the main divider never exceeds 800000 / 1250 = 640.
    localparam int QUOT_BITS      = 10;
    // The divisor is reference / 8, at most 2500 for a valid reference.
    localparam int DEN_BITS       = 12;
    localparam int STEPS_PER_STG  = 2;
    localparam int DIV_STAGES     = QUOT_BITS / STEPS_PER_STG;
    localparam int PROD_BITS      = FREQ_BITS + QUOT_BITS;

    localparam logic [FREQ_BITS-1:0] REF_MIN   = FREQ_BITS'(10000);
    localparam logic [FREQ_BITS-1:0] REF_MAX   = FREQ_BITS'(20000);
    localparam logic [FREQ_BITS-1:0] TGT_MIN   = FREQ_BITS'(50000);
    localparam logic [FREQ_BITS-1:0] TGT_MAX   = FREQ_BITS'(800000);
    // Output divider thresholds: 800000 / target reaches 2, 4, 8 at these.
    localparam logic [FREQ_BITS-1:0] TGT_HALF  = FREQ_BITS'(400000);
    localparam logic [FREQ_BITS-1:0] TGT_QUART = FREQ_BITS'(200000);
    localparam logic [FREQ_BITS-1:0] TGT_EIGHT = FREQ_BITS'(100000);
    localparam logic [ACT_BITS-1:0]  ACT_MAX   = {ACT_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_REF_BAD   = 3'd1,
        ST_TOO_LOW   = 3'd2,
        ST_TOO_HIGH  = 3'd3,
        ST_DIV_RANGE = 3'd4
    } status_t;

    // Restoring division state: low holds the numerator bits still to be
    // shifted in at the top and collects quotient bits at the bottom.
    typedef struct packed {
        logic [DEN_BITS-1:0]  rem;
        logic [QUOT_BITS-1:0] low;
        logic [DEN_BITS-1:0]  den;
    } div_state_t;

    typedef struct packed {
        status_t    status;
        logic [1:0] pw;
        div_state_t div;
    } pipe_t;

endpackage

// File: src/pds_precheck.sv
// ----------------------------------------------------------------------------
// PLL divider solver: range checks
// Checks reference and target ranges, picks the output divider power and
// sets up the main divider numerator and divisor.
// ----------------------------------------------------------------------------
module pds_precheck
    import pds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [FREQ_BITS-1:0] reference_khz,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FREQ_BITS-1:0] in_target_khz,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pipe_t                out_data
);

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;
    logic [FREQ_BITS-1:0] numer;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next = '0;
        priority if (reference_khz < REF_MIN || reference_khz > REF_MAX) begin
            data_next.status = ST_REF_BAD;
        end else if (in_target_khz < TGT_MIN) begin
            data_next.status = ST_TOO_LOW;
        end else if (in_target_khz > TGT_MAX) begin
            data_next.status = ST_TOO_HIGH;
        end else begin
            data_next.status = ST_OK;
        end

        // The power saturates at 3, which also covers exactly 50 MHz.
        priority if (in_target_khz <= TGT_EIGHT) begin
            data_next.pw = 2'd3;
        end else if (in_target_khz <= TGT_QUART) begin
            data_next.pw = 2'd2;
        end else if (in_target_khz <= TGT_HALF) begin
            data_next.pw = 2'd1;
        end else begin
            data_next.pw = 2'd0;
        end

        // For a target in range the shifted value stays within 800000.
        numer = in_target_khz << data_next.pw;
        data_next.div.rem = DEN_BITS'(numer[FREQ_BITS-1:QUOT_BITS]);
        data_next.div.low = numer[QUOT_BITS-1:0];
        data_next.div.den = reference_khz[DEN_BITS+2:3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: src/pds_div_stage.sv
// ----------------------------------------------------------------------------
// PLL divider solver: divider stage
// One pipeline stage of the restoring main divider, retiring two quotient
// bits per cycle while its output is not stalled.
// ----------------------------------------------------------------------------
module pds_div_stage
    import pds_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  pipe_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output pipe_t out_data
);

    function automatic div_state_t div_step(div_state_t d);
        logic [DEN_BITS:0] shifted;
        logic [DEN_BITS:0] diff;
        logic              qbit;
        div_state_t        r;
        shifted = {d.rem, d.low[QUOT_BITS-1]};
        diff    = shifted - {1'b0, d.den};
        qbit    = (shifted >= {1'b0, d.den});
        r       = d;
        r.rem   = qbit ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
        r.low   = {d.low[QUOT_BITS-2:0], qbit};
        return r;
    endfunction

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next = in_data;
        for (int i = 0; i < STEPS_PER_STG; i++) begin
            data_next.div = div_step(data_next.div);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: src/pds_finish.sv
// ----------------------------------------------------------------------------
// PLL divider solver: result stages
// Checks the main divider range and multiplies out the produced frequency,
// then scales it and packs the control word into the output register.
// ----------------------------------------------------------------------------
module pds_finish
    import pds_pkg::*;
#(
    parameter int MAIN_DIV_BITS = MAIN_DIV_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [FREQ_BITS-1:0] reference_khz,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pipe_t                in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output status_t              out_status,
    output logic [CW_BITS-1:0]   out_control_word,
    output logic [ACT_BITS-1:0]  out_actual_khz
);

    localparam int SHIFT_BITS = PROD_BITS - 3;

    // Multiply stage.
    logic                  a_valid_reg;
    logic                  a_ready;
    status_t               a_status_reg;
    status_t               a_status_next;
    logic [1:0]            a_pw_reg;
    logic [QUOT_BITS-1:0]  a_m_reg;
    logic [PROD_BITS-1:0]  a_prod_reg;
    logic [PROD_BITS-1:0]  a_prod_next;

    // Output register.
    logic                  b_valid_reg;
    status_t               b_status_reg;
    logic [CW_BITS-1:0]    b_cw_reg;
    logic [CW_BITS-1:0]    b_cw_next;
    logic [ACT_BITS-1:0]   b_act_reg;
    logic [ACT_BITS-1:0]   b_act_next;
    logic [SHIFT_BITS-1:0] scaled;
    logic [1:0]            code;

    assign in_ready = !a_valid_reg || a_ready;
    assign a_ready  = !b_valid_reg || out_ready;

    always_comb begin
        a_status_next = in_data.status;
        if (in_data.status == ST_OK &&
            (in_data.div.low == '0 || (in_data.div.low >> MAIN_DIV_BITS) != '0)) begin
            a_status_next = ST_DIV_RANGE;
        end
        a_prod_next = PROD_BITS'(reference_khz) * PROD_BITS'(in_data.div.low);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            a_status_reg <= a_status_next;
            a_pw_reg     <= in_data.pw;
            a_m_reg      <= in_data.div.low;
            a_prod_reg   <= a_prod_next;
        end
    end

    // Output ratio 2^pw maps to codes 3, 0, 1, 2.
    always_comb begin
        code   = a_pw_reg + 2'd3;
        scaled = SHIFT_BITS'(a_prod_reg >> (3 + a_pw_reg));
        if (a_status_reg == ST_OK) begin
            b_cw_next  = (CW_BITS'(code) << MAIN_DIV_BITS) | CW_BITS'(a_m_reg);
            b_act_next = (scaled > SHIFT_BITS'(ACT_MAX)) ? ACT_MAX
                                                         : scaled[ACT_BITS-1:0];
        end else begin
            b_cw_next  = '0;
            b_act_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && a_valid_reg) begin
            b_status_reg <= a_status_reg;
            b_cw_reg     <= b_cw_next;
            b_act_reg    <= b_act_next;
        end
    end

    assign out_valid        = b_valid_reg;
    assign out_status       = b_status_reg;
    assign out_control_word = b_cw_reg;
    assign out_actual_khz   = b_act_reg;

endmodule

// File: src/pll_divider_solver.sv
// ----------------------------------------------------------------------------
// PLL divider solver
// Solves output and main divider settings for a requested PLL frequency.
// ----------------------------------------------------------------------------
// Accepts one target frequency per clock while the result side is not
// stalled, and returns one result per target, in order. Each result passes
// through the range check stage, the five stages of the main divider (two
// quotient bits per stage), a multiply stage and the output register. The
// reference frequency register is written through the cfg channel, which is
// always ready; write it only while no request is in flight.
// ----------------------------------------------------------------------------
module pll_divider_solver
    import pds_pkg::*;
#(
    parameter int MAIN_DIV_BITS = MAIN_DIV_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [FREQ_BITS-1:0] cfg_reference_khz,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FREQ_BITS-1:0] s_target_khz,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [CW_BITS-1:0]   m_control_word,
    output logic [ACT_BITS-1:0]  m_actual_khz
);

    logic [FREQ_BITS-1:0] reference_reg;
    pipe_t                stg_data  [0:DIV_STAGES];
    logic [DIV_STAGES:0]  stg_valid;
    logic [DIV_STAGES:0]  stg_ready;
    status_t              status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reference_reg <= REF_MIN;
        end else if (cfg_valid) begin
            reference_reg <= cfg_reference_khz;
        end
    end

    pds_precheck u_precheck (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .reference_khz (reference_reg),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_target_khz (s_target_khz),
        .out_valid     (stg_valid[0]),
        .out_ready     (stg_ready[0]),
        .out_data      (stg_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        pds_div_stage u_div_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    pds_finish #(
        .MAIN_DIV_BITS (MAIN_DIV_BITS)
    ) u_finish (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .reference_khz    (reference_reg),
        .in_valid         (stg_valid[DIV_STAGES]),
        .in_ready         (stg_ready[DIV_STAGES]),
        .in_data          (stg_data[DIV_STAGES]),
        .out_valid        (m_valid),
        .out_ready        (m_ready),
        .out_status       (status),
        .out_control_word (m_control_word),
        .out_actual_khz   (m_actual_khz)
    );

    assign m_status = status;

endmodule
